// File: src/mbhe_pkg.sv
// Package for the masked Bayer histogram entropy unit.
// Shared sizes, constants, the unit status struct and the bin clamp function.
// No dependencies.
`default_nettype none
package mbhe_pkg;

  localparam int BIN_COUNT       = 1024;
  localparam int MAX_PIXELS_LOG2 = 20;
  localparam int CH_COUNT        = 3;
  localparam int TOT_BINS        = CH_COUNT * BIN_COUNT;
  localparam int ADDR_W          = $clog2(TOT_BINS);
  localparam int BIN_W           = $clog2(BIN_COUNT);
  localparam int SAMPLE_W        = 10;
  localparam int MASK_W          = 8;
  localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
  localparam int E_W             = $clog2(CNT_W);
  localparam int LN_W            = E_W + 16;
  localparam int FRAC_STEPS      = 16;
  localparam int STEP_W          = $clog2(FRAC_STEPS);
  localparam int MANT_W          = 31;
  localparam int PROD_W          = CNT_W + LN_W;
  localparam int NUM_W           = PROD_W + 3;
  localparam int ENT_W           = 21;
  localparam int CNT_OUT_W       = 21;

  localparam logic [CNT_W-1:0] PIXEL_CAP   = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};
  localparam logic [31:0]      LN2_Q32     = 32'd2977044472;
  localparam logic [ENT_W-1:0] ENTROPY_MAX = 21'd1363200;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [SAMPLE_W-1:0] s);
    int v;
    v = int'(s);
    if (v >= BIN_COUNT) v = BIN_COUNT - 1;
    return BIN_W'(v);
  endfunction

endpackage
`default_nettype wire

// File: src/mbhe_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module mbhe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/mbhe_ln.sv
// Iterative natural log in Q16: leading-one, 16 squaring steps, scale by ln 2.
// Depends on mbhe_pkg.
`default_nettype none
module mbhe_ln (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [mbhe_pkg::CNT_W-1:0] x_i,
  output      mbhe_pkg::unit_sts_t      sts_o,
  output      logic [mbhe_pkg::LN_W-1:0] ln_o
);
  import mbhe_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_SQ, L_MUL, L_RND} ln_state_e;

  ln_state_e           state_q;
  logic [E_W-1:0]      e_q;
  logic [MANT_W-1:0]   m_q;
  logic [15:0]         frac_q;
  logic [STEP_W-1:0]   step_q;
  logic [LN_W+31:0]    prod_q;
  logic                done_q;
  logic [LN_W-1:0]     ln_q;

  logic [E_W-1:0]      e_start;
  logic [MANT_W-1:0]   m_start;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     m_sq;
  logic [LN_W+31:0]    rnd;

  always_comb begin
    e_start = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (x_i[b]) e_start = E_W'(b);
    end
    m_start = MANT_W'(MANT_W'(x_i) << (E_W'(MANT_W - 1) - e_start));
    sq      = (2*MANT_W)'(m_q) * (2*MANT_W)'(m_q);
    m_sq    = sq[2*MANT_W-1:MANT_W-1];
    rnd     = prod_q + (LN_W+32)'(64'h8000_0000);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            e_q     <= e_start;
            m_q     <= m_start;
            frac_q  <= '0;
            step_q  <= '0;
            state_q <= L_SQ;
          end
        end
        L_SQ: begin
          // halve when the square reaches 2.0 and emit a one
          if (m_sq[MANT_W]) begin
            m_q    <= m_sq[MANT_W:1];
            frac_q <= {frac_q[14:0], 1'b1};
          end else begin
            m_q    <= m_sq[MANT_W-1:0];
            frac_q <= {frac_q[14:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(FRAC_STEPS - 1)) state_q <= L_MUL;
        end
        L_MUL: begin
          prod_q  <= (LN_W+32)'({e_q, frac_q}) * (LN_W+32)'(LN2_Q32);
          state_q <= L_RND;
        end
        L_RND: begin
          ln_q    <= rnd[LN_W+31:32];
          done_q  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign sts_o.busy = (state_q != L_IDLE);
  assign sts_o.done = done_q;
  assign ln_o       = ln_q;

endmodule
`default_nettype wire

// File: src/mbhe_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on mbhe_pkg.
`default_nettype none
module mbhe_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [mbhe_pkg::NUM_W-1:0] num_i,
  input  wire logic [mbhe_pkg::CNT_W-1:0] den_i,
  output      mbhe_pkg::unit_sts_t        sts_o,
  output      logic [mbhe_pkg::NUM_W-1:0] quot_o
);
  import mbhe_pkg::*;

  localparam int ITER_W = $clog2(NUM_W);

  logic              busy_q;
  logic              done_q;
  logic [ITER_W-1:0] iter_q;
  logic [NUM_W-1:0]  num_q;
  logic [CNT_W-1:0]  den_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          num_q  <= num_i;
          den_q  <= den_i;
          rem_q  <= '0;
          iter_q <= '0;
          busy_q <= 1'b1;
        end
      end else begin
        rem_q  <= fits ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
        num_q  <= {num_q[NUM_W-2:0], fits};
        iter_q <= iter_q + 1'b1;
        if (iter_q == ITER_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = num_q;

endmodule
`default_nettype wire

// File: src/masked_bayer_histogram_entropy_unit.sv
// Top level: three-channel histogram RAM, frame-end bin walk, entropy result.
// Depends on mbhe_pkg, mbhe_ram, mbhe_ln and mbhe_div.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-------------------------------------------
//  pixel   | in_valid_i   | in_stall_o   | red/green/blue_sample_i, mask_value_i,
//          |              |              | frame_end_i
//  result  | out_valid_o  | out_stall_i  | entropy_q16_o, counted_pixels_o,
//          |              |              | count_overflow_o
//  config  | cfg_we_i     | -            | cfg_wdata_i (mask_enable)
//
// A counted pixel is a read-modify-write of three bins in the one RAM, one channel at a time;
// a refused one leaves the RAM alone. At frame end the bin walk reads every bin and runs
// the iterative ln for each nonzero bin, then takes ln N and the divide.
// After reset a clearing pass writes all 3072 bins, with the pixel side stalled.
// The result sits in an output register; a further frame end waits while it is stalled.
`default_nettype none
module masked_bayer_histogram_entropy_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output      logic                             in_stall_o,
  input  wire logic [mbhe_pkg::SAMPLE_W-1:0]    red_sample_i,
  input  wire logic [mbhe_pkg::SAMPLE_W-1:0]    green_sample_i,
  input  wire logic [mbhe_pkg::SAMPLE_W-1:0]    blue_sample_i,
  input  wire logic [mbhe_pkg::MASK_W-1:0]      mask_value_i,
  input  wire logic                             frame_end_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_stall_i,
  output      logic [mbhe_pkg::ENT_W-1:0]       entropy_q16_o,
  output      logic [mbhe_pkg::CNT_OUT_W-1:0]   counted_pixels_o,
  output      logic                             count_overflow_o,
  input  wire logic                             cfg_we_i,
  input  wire logic                             cfg_wdata_i
);
  import mbhe_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_WR, S_WRD, S_WDAT, S_WLN, S_WACC,
    S_NLN, S_NWAIT, S_NMUL, S_DWAIT, S_DONE
  } top_state_e;

  top_state_e           state_q;
  logic                 mask_en_q;
  logic [SAMPLE_W-1:0]  red_q, green_q, blue_q;
  logic                 frame_end_q;
  logic [1:0]           ch_q;
  logic [ADDR_W-1:0]    idx_q;
  logic [CNT_W-1:0]     pix_total_q;
  logic                 overflow_q;
  logic [CNT_W-1:0]     h_q;
  logic [PROD_W-1:0]    prod_q;
  logic [NUM_W-1:0]     sum_q;
  logic [ENT_W-1:0]     res_q;

  logic                 out_valid_q;
  logic [ENT_W-1:0]     out_ent_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  logic                 out_ovf_q;

  logic                 in_acc;
  logic                 counts;
  logic [BIN_W-1:0]     bin;
  logic [ADDR_W-1:0]    pix_addr;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [CNT_W-1:0]     ram_wdata, ram_rdata;
  logic                 ln_start;
  logic [CNT_W-1:0]     ln_x;
  unit_sts_t            ln_sts;
  logic [LN_W-1:0]      ln_res;
  logic                 div_start;
  logic [NUM_W-1:0]     whole, div_num;
  unit_sts_t            div_sts;
  logic [NUM_W-1:0]     div_quot;
  logic                 out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign counts     = !mask_en_q || (mask_value_i != '0);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    case (ch_q)
      2'd0:    bin = bin_of(red_q);
      2'd1:    bin = bin_of(green_q);
      default: bin = bin_of(blue_q);
    endcase
    pix_addr = ADDR_W'(int'(ch_q) * BIN_COUNT) + ADDR_W'(bin);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = '0;
    ram_raddr = pix_addr;
    unique case (state_q)
      S_CLR:  ram_we = 1'b1;
      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pix_addr;
        ram_wdata = ram_rdata + 1'b1;
      end
      S_WRD:  ram_raddr = idx_q;
      S_WDAT: ram_we = 1'b1;
      default: ;
    endcase
  end

  assign whole     = NUM_W'(prod_q) + NUM_W'({prod_q, 1'b0});
  assign div_num   = whole - sum_q + NUM_W'(pix_total_q >> 1);
  assign ln_start  = ((state_q == S_WDAT) && (ram_rdata != '0)) ||
                     ((state_q == S_NLN) && (pix_total_q != '0));
  assign ln_x      = (state_q == S_WDAT) ? ram_rdata : pix_total_q;
  assign div_start = (state_q == S_NMUL) && (sum_q < whole);

  mbhe_ram #(.WIDTH(CNT_W), .DEPTH(TOT_BINS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mbhe_ln u_ln (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ln_start),
    .x_i     (ln_x),
    .sts_o   (ln_sts),
    .ln_o    (ln_res)
  );

  mbhe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (pix_total_q),
    .sts_o   (div_sts),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      mask_en_q   <= 1'b0;
      idx_q       <= '0;
      ch_q        <= '0;
      pix_total_q <= '0;
      overflow_q  <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      frame_end_q <= 1'b0;
    end else begin
      if (cfg_we_i) mask_en_q <= cfg_wdata_i;
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) out_valid_q <= 1'b0;

      unique case (state_q)
        S_CLR: begin
          if (idx_q == ADDR_W'(TOT_BINS - 1)) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            red_q       <= red_sample_i;
            green_q     <= green_sample_i;
            blue_q      <= blue_sample_i;
            frame_end_q <= frame_end_i;
            ch_q        <= '0;
            idx_q       <= '0;
            if (counts && (pix_total_q < PIXEL_CAP)) begin
              state_q <= S_RD;
            end else begin
              if (counts) overflow_q <= 1'b1;
              if (frame_end_i) state_q <= S_WRD;
            end
          end
        end
        S_RD: state_q <= S_WR;
        S_WR: begin
          if (ch_q == 2'(CH_COUNT - 1)) begin
            pix_total_q <= pix_total_q + 1'b1;
            state_q     <= frame_end_q ? S_WRD : S_IDLE;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_WRD: state_q <= S_WDAT;
        S_WDAT: begin
          h_q <= ram_rdata;
          if (ram_rdata != '0) begin
            state_q <= S_WLN;
          end else if (idx_q == ADDR_W'(TOT_BINS - 1)) begin
            state_q <= S_NLN;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_WRD;
          end
        end
        S_WLN: begin
          if (ln_sts.done) begin
            prod_q  <= PROD_W'(h_q) * PROD_W'(ln_res);
            state_q <= S_WACC;
          end
        end
        S_WACC: begin
          sum_q <= sum_q + NUM_W'(prod_q);
          if (idx_q == ADDR_W'(TOT_BINS - 1)) begin
            state_q <= S_NLN;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_WRD;
          end
        end
        S_NLN: begin
          if (pix_total_q == '0) begin
            res_q   <= '0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_NWAIT;
          end
        end
        S_NWAIT: begin
          if (ln_sts.done) begin
            prod_q  <= PROD_W'(pix_total_q) * PROD_W'(ln_res);
            state_q <= S_NMUL;
          end
        end
        S_NMUL: begin
          if (sum_q >= whole) begin
            res_q   <= '0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_sts.done) begin
            // saturate the estimate
            res_q   <= (div_quot > NUM_W'(ENTROPY_MAX)) ? ENTROPY_MAX
                                                        : div_quot[ENT_W-1:0];
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ent_q   <= res_q;
            out_cnt_q   <= CNT_OUT_W'(pix_total_q);
            out_ovf_q   <= overflow_q;
            pix_total_q <= '0;
            overflow_q  <= 1'b0;
            sum_q       <= '0;
            idx_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign entropy_q16_o    = out_ent_q;
  assign counted_pixels_o = out_cnt_q;
  assign count_overflow_o = out_ovf_q;

`ifndef SYNTHESIS
  a_rmw_same_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> (ram_waddr == $past(ram_raddr)))
    else $error("bin write-back address differs from the read address");

  a_total_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_total_q <= PIXEL_CAP)
    else $error("pixel total beyond its cap");

  a_ln_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ln_start |-> !ln_sts.busy)
    else $error("ln unit started while busy");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");
`endif

endmodule
`default_nettype wire

// File: dv/tb_masked_bayer_histogram_entropy_unit.sv
// Self-checking testbench for masked_bayer_histogram_entropy_unit: frames of superpixels
// against a behavioural entropy predictor, with random bursts, output stalls and a hold-off.
// Depends on mbhe_pkg and the unit RTL.
module tb_masked_bayer_histogram_entropy_unit;
  import mbhe_pkg::*;

  localparam int  MAX_SHOWN   = 10;
  localparam int  DRAIN_WAIT  = 40;
  localparam int  TAIL_WAIT   = 200;
  localparam int  HOLD_LEN    = 40000;
  localparam int  HOLD_AT     = 900;
  localparam longint CYCLE_LIMIT = 8000000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [MASK_W-1:0]   mask;
    logic                last;
  } pixel_t;

  typedef struct packed {
    logic [ENT_W-1:0]     entropy;
    logic [CNT_OUT_W-1:0] pixels;
    logic                 overflow;
  } frame_stat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [SAMPLE_W-1:0] red_sample_i = '0, green_sample_i = '0, blue_sample_i = '0;
  logic [MASK_W-1:0] mask_value_i = '0;
  logic frame_end_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ENT_W-1:0] entropy_q16_o;
  logic [CNT_OUT_W-1:0] counted_pixels_o;
  logic count_overflow_o;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  masked_bayer_histogram_entropy_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .red_sample_i, .green_sample_i, .blue_sample_i, .mask_value_i, .frame_end_i,
    .out_valid_o, .out_stall_i, .entropy_q16_o, .counted_pixels_o, .count_overflow_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  pixel_t      pixel_q[$];
  frame_stat_t frame_stat_q[$];
  int unsigned bin_count[TOT_BINS];
  longint unsigned pixel_sum;
  bit          refused_seen;
  bit          masking;
  int          mismatches;
  int          accepted;
  bit          taken;
  longint      cycles;

  function automatic longint unsigned ln_fix(longint unsigned x);
    int e;
    longint unsigned m, frac, lg;
    e = 0;
    frac = 0;
    if (x == 0) return 0;
    while (e < 30 && (x >> (e + 1)) != 0) e++;
    m = (x << (30 - e)) & 64'h7FFF_FFFF;
    for (int i = 0; i < FRAC_STEPS; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    lg = (longint'(e) << 16) | frac;
    return (lg * 64'd2977044472 + (64'd1 << 31)) >> 32;
  endfunction

  function automatic int clamp_bin(logic [SAMPLE_W-1:0] s);
    return (int'(s) >= BIN_COUNT) ? BIN_COUNT - 1 : int'(s);
  endfunction

  function automatic longint unsigned frame_entropy();
    longint unsigned n, acc, whole, q;
    n = pixel_sum;
    acc = 0;
    if (n == 0) return 0;
    for (int i = 0; i < TOT_BINS; i++)
      if (bin_count[i] != 0) acc += longint'(bin_count[i]) * ln_fix(bin_count[i]);
    whole = 3 * n * ln_fix(n);
    if (acc >= whole) return 0;
    q = (whole - acc + n / 2) / n;
    return (q > 1363200) ? 1363200 : q;
  endfunction

  // Update the histograms for one accepted word; queue the frame result on the last one.
  function automatic void count_pixel(pixel_t p);
    frame_stat_t s;
    if (!masking || p.mask != 0) begin
      if (pixel_sum < (64'd1 << MAX_PIXELS_LOG2)) begin
        bin_count[clamp_bin(p.red)]++;
        bin_count[BIN_COUNT + clamp_bin(p.green)]++;
        bin_count[2 * BIN_COUNT + clamp_bin(p.blue)]++;
        pixel_sum++;
      end else begin
        refused_seen = 1'b1;
      end
    end
    if (p.last) begin
      s.entropy  = ENT_W'(frame_entropy());
      s.pixels   = CNT_OUT_W'(pixel_sum);
      s.overflow = refused_seen;
      frame_stat_q.push_back(s);
      foreach (bin_count[i]) bin_count[i] = 0;
      pixel_sum = 0;
      refused_seen = 1'b0;
    end
  endfunction

  // Driver: accept at the rising edge, present the next word at the falling edge.
  int burst_left = 1, gap_left = 0;
  always @(posedge clk_i) begin
    taken = in_valid_i && !in_stall_o;
    if (taken) begin
      count_pixel(pixel_q.pop_front());
      accepted++;
    end
  end

  always @(negedge clk_i) begin
    if (!(in_valid_i && !taken)) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pixel_q.size() != 0) begin
        in_valid_i     <= 1'b1;
        red_sample_i   <= pixel_q[0].red;
        green_sample_i <= pixel_q[0].green;
        blue_sample_i  <= pixel_q[0].blue;
        mask_value_i   <= pixel_q[0].mask;
        frame_end_i    <= pixel_q[0].last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off so the unit backs up.
  int stall_mode = 0, mode_left = 0, hold_left = 0;
  bit hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (!hold_done && accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 3000);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor: compare each result word with the oldest expected frame.
  always @(posedge clk_i) begin
    frame_stat_t e;
    if (out_valid_o && !out_stall_i) begin
      if (frame_stat_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected result word: %0d %0d %0d",
          entropy_q16_o, counted_pixels_o, count_overflow_o);
      end else begin
        e = frame_stat_q.pop_front();
        if (e.entropy !== entropy_q16_o || e.pixels !== counted_pixels_o ||
            e.overflow !== count_overflow_o) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: exp entropy %0d pixels %0d ovf %0d, got %0d %0d %0d",
              e.entropy, e.pixels, e.overflow,
              entropy_q16_o, counted_pixels_o, count_overflow_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample(int spread);
    case (spread)
      0: return SAMPLE_W'($urandom_range(0, 3));
      1: return SAMPLE_W'($urandom_range(500, 531));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void add_pixel(int r, int g, int b, int m, bit last);
    pixel_t p;
    p.red = SAMPLE_W'(r); p.green = SAMPLE_W'(g); p.blue = SAMPLE_W'(b);
    p.mask = MASK_W'(m); p.last = last;
    pixel_q.push_back(p);
  endfunction

  // One random frame; mostly counted pixels, some masked-out noise.
  function automatic void add_frame(int len);
    int spread;
    int m;
    spread = $urandom_range(0, 2);
    for (int i = 0; i < len; i++) begin
      m = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255);
      add_pixel(int'(rand_sample(spread)), int'(rand_sample(spread)),
                int'(rand_sample(spread)), m, i == len - 1);
    end
  endfunction

  task automatic drain();
    while (pixel_q.size() != 0 || frame_stat_q.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_mask(bit v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    masking = v;
  endtask

  initial begin
    int sent;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Extremes, a single pixel (zero estimate), a two-pixel and a three-pixel frame, masking off.
    add_pixel(0, 0, 0, 0, 1'b1);
    add_pixel(1023, 1023, 1023, 255, 1'b0);
    add_pixel(0, 1023, 0, 0, 1'b1);
    add_pixel(1023, 0, 1023, 1, 1'b0);
    add_pixel(1023, 0, 1023, 1, 1'b0);
    add_pixel(682, 341, 5, 128, 1'b1);
    drain();

    // Masking on: an empty frame, then masked and counted pixels mixed.
    write_mask(1'b1);
    add_pixel(7, 8, 9, 0, 1'b0);
    add_pixel(7, 8, 9, 0, 1'b1);
    add_pixel(1023, 0, 512, 255, 1'b0);
    add_pixel(0, 1023, 511, 0, 1'b0);
    add_pixel(1, 2, 3, 1, 1'b0);
    add_pixel(1023, 1023, 1023, 0, 1'b1);
    add_pixel(100, 200, 300, 170, 1'b0);
    add_pixel(100, 200, 300, 85, 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      write_mask(phase[0] ? 1'b0 : 1'b1);
      sent = 0;
      while (sent < 385) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(10, 80);
        add_frame(len);
        sent += len;
      end
      drain();
    end
    write_mask(1'b0);

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0 && frame_stat_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
